// ----- rtl/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg
// Types, codes and defaults shared by the heap slot placement block.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int HEAP_TABLE_DEPTH_DEF = 1024;
  localparam int TEMP_SLOTS_DEF       = 2;
  localparam int IMMEDIATE_BITS_DEF   = 48;

  localparam int FIELD_W = 48;
  localparam int SLOT_W  = 28;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DST_DATA  = 2'd0,
    DST_TEMP  = 2'd1,
    DST_TRASH = 2'd2
  } dst_e;

  typedef enum logic [2:0] {
    RSN_PLACED   = 3'd0,
    RSN_IGNORED  = 3'd1,
    RSN_SKIPPED  = 3'd2,
    RSN_TIMEERR  = 3'd3,
    RSN_ENGSKIP  = 3'd4,
    RSN_CHANSKIP = 3'd5,
    RSN_OVERRUN  = 3'd6,
    RSN_NONE     = 3'd7
  } rsn_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_DATA_REL  = 2'd1,
    EV_TEMP_REL  = 2'd2
  } ev_e;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_SEQ  = 2'd1,
    PH_PAR  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CFG_CHANNEL_FIRST = 3'd0,
    CFG_CHANNEL_STEP  = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_ENGINE_FIRST  = 3'd3,
    CFG_ENGINE_COUNT  = 3'd4,
    CFG_TICK_STEP     = 3'd5,
    CFG_DATA_SLOTS    = 3'd6,
    CFG_BUFFER_MODE   = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_IDX,
    S_IDX_DONE,
    S_MARK,
    S_INIT,
    S_TI_LOAD,
    S_TI,
    S_FI_LOAD,
    S_FI,
    S_CHECK,
    S_MUL_A,
    S_MUL_B,
    S_OUT
  } state_e;

endpackage

// ----- rtl/hsp_if.sv -----
// ----------------------------------------------------------------------------
// hsp_in_if / hsp_out_if
// Valid/ready channels carrying heap commands in and placements out.
// ----------------------------------------------------------------------------
interface hsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] heap_counter;
  logic [47:0] timestamp;
  logic [47:0] engine_id;
  logic [47:0] frequency;

  modport source (output valid, command, heap_counter, timestamp, engine_id, frequency,
                  input ready);
  modport sink   (input valid, command, heap_counter, timestamp, engine_id, frequency,
                  output ready);
endinterface

interface hsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  destination;
  logic [27:0] slot_index;
  logic [2:0]  reason;
  logic [1:0]  switch_event;
  logic        stopped;

  modport source (output valid, destination, slot_index, reason, switch_event, stopped,
                  input ready);
  modport sink   (input valid, destination, slot_index, reason, switch_event, stopped,
                  output ready);
endinterface

// ----- rtl/hsp_ram.sv -----
// ----------------------------------------------------------------------------
// hsp_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/heap_slot_placement.sv -----
// ----------------------------------------------------------------------------
// heap_slot_placement
// Decides buffer and heap slot for each received heap, tracks buffer phases.
// ----------------------------------------------------------------------------
// Usage: commands arrive on item_i (allocate, mark done, request stop), one
// placement result leaves on result_o for every accepted item. The user is
// to write configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while
// the block is idle; the block does not enforce this. One item is processed
// at a time; item_i.ready is high only when idle. Stop and unused commands,
// and an allocate of heap counter one, go from decode straight to the result;
// mark reads the heap table first. Allocate uses a 49-step restoring divider
// shared between the time index and the channel index, one quotient bit per
// cycle. The heap table index is the heap counter modulo the table depth, its
// low bits for a power-of-two depth; for other depths the divider finds it
// too. The next item can be accepted in the cycle after the result is taken.
// The result is held in registers while result_o.ready is low. Reset puts
// the block in the init phase with all countdowns zero and the configuration
// at its defaults; the heap destination table is not cleared, so marking a
// heap that was never allocated gives an undefined destination.
// ----------------------------------------------------------------------------
module heap_slot_placement
  import hsp_pkg::*;
#(
  parameter int HEAP_TABLE_DEPTH = HEAP_TABLE_DEPTH_DEF,
  parameter int TEMP_SLOTS       = TEMP_SLOTS_DEF,
  parameter int IMMEDIATE_BITS   = IMMEDIATE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsp_in_if.sink      item_i,
  hsp_out_if.source   result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  localparam int IW       = $clog2(HEAP_TABLE_DEPTH);
  localparam int NUM_W    = FIELD_W + 1;
  localparam int DIV_LAST = NUM_W - 1;
  localparam int IMM_KEEP = (IMMEDIATE_BITS < FIELD_W) ? IMMEDIATE_BITS : FIELD_W;
  localparam logic [FIELD_W-1:0] IMM_MASK = {FIELD_W{1'b1}} >> (FIELD_W - IMM_KEEP);
  localparam bit IDX_POW2 = (HEAP_TABLE_DEPTH & (HEAP_TABLE_DEPTH - 1)) == 0;

  state_e state_q, state_d;

  // latched item
  cmd_e               cmd_q;
  logic [FIELD_W-1:0] cnt_q, ts_q, eng_q, fr_q;

  // configuration
  logic [47:0] cf_q;
  logic [31:0] cs_q;
  logic [12:0] cc_q;
  logic [5:0]  ef_q;
  logic [6:0]  ec_q;
  logic [31:0] tk_q;
  logic [15:0] ds_q;
  logic [2:0]  bm_q;
  logic [19:0] cc_ec_q;
  logic [47:0] ds_tk_q;

  // placement state
  phase_e      phase_q, phase_d;
  logic [47:0] ws_q, ws_d;
  logic [31:0] dc_q, dc_d, tc_q, tc_d;
  logic        sp_q, sp_d, hs_q, hs_d;

  // shared divider
  logic [31:0]      div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [NUM_W-1:0] div_quo_q, div_quo_d;
  logic [5:0]       div_cnt_q, div_cnt_d;
  logic [32:0]      div_trial;
  logic             div_ge;
  logic [32:0]      div_sub;
  logic [31:0]      div_rem_nx;
  logic [NUM_W-1:0] div_quo_nx;
  logic             div_done;

  // working registers
  logic [IW-1:0]    idx_q, idx_d;
  logic [NUM_W-1:0] ti_q, ti_d, fi_q, fi_d;
  logic [16:0]      tsl_q, tsl_d;
  logic [1:0]       dst_q, dst_d;
  logic [2:0]       rsn_q, rsn_d;
  logic [1:0]       ev_q, ev_d;
  logic [27:0]      slot_q, slot_d;

  // ram
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [1:0]    ram_wdata, ram_rdata;

  // helpers
  logic [31:0]      tk_nz, cs_nz;
  logic [5:0]       eng6, ei;
  logic [36:0]      prod_a;
  logic [18:0]      prod_b;
  logic [16:0]      ds_ext, ds_temp;
  logic [NUM_W-1:0] ti_num, fi_num;
  logic [31:0]      dc_dec, tc_dec;
  logic [IW-1:0]    idx_new;

  logic in_acc, out_acc;
  assign in_acc  = item_i.valid && item_i.ready;
  assign out_acc = result_o.valid && result_o.ready;

  assign tk_nz   = (tk_q == '0) ? 32'd1 : tk_q;
  assign cs_nz   = (cs_q == '0) ? 32'd1 : cs_q;
  assign eng6    = (eng_q > 48'd63) ? 6'd0 : eng_q[5:0];
  assign ei      = eng6 - ef_q;
  assign ds_ext  = {1'b0, ds_q};
  assign ds_temp = ds_ext + 17'(TEMP_SLOTS);
  assign prod_a  = 37'(tsl_q) * 37'(cc_ec_q);
  assign prod_b  = 19'(ei) * 19'(cc_q);

  // power-of-two depth: table index is the low bits of the heap counter
  assign idx_new = IDX_POW2 ? cnt_q[IW-1:0] : div_rem_q[IW-1:0];

  assign ti_num = (ts_q >= ws_q) ? ({1'b0, ts_q - ws_q} + NUM_W'(tk_nz[31:1])) : '0;
  assign fi_num = (fr_q >= cf_q) ? ({1'b0, fr_q - cf_q} + NUM_W'(cs_nz[31:1])) : '0;

  // one restoring step: one quotient bit a cycle
  assign div_trial  = {div_rem_q, div_quo_q[NUM_W-1]};
  assign div_ge     = div_trial >= {1'b0, div_den_q};
  assign div_sub    = div_trial - {1'b0, div_den_q};
  assign div_rem_nx = div_ge ? div_sub[31:0] : div_trial[31:0];
  assign div_quo_nx = {div_quo_q[NUM_W-2:0], div_ge};
  assign div_done   = div_cnt_q == 6'(DIV_LAST);

  always_comb begin
    dc_dec = dc_q;
    tc_dec = tc_q;
    if (ram_rdata == DST_DATA) begin
      dc_dec = dc_q - 32'd1;
    end else if (ram_rdata == DST_TEMP) begin
      tc_dec = tc_q - 32'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = S_DECODE;
      S_DECODE: begin
        if (cmd_q == CMD_MARK || (cmd_q == CMD_ALLOC && cnt_q != 48'd1)) begin
          state_d = IDX_POW2 ? S_IDX_DONE : S_IDX;
        end else begin
          state_d = S_OUT;
        end
      end
      S_IDX:      if (div_done) state_d = S_IDX_DONE;
      S_IDX_DONE: state_d = (cmd_q == CMD_MARK) ? S_MARK : S_INIT;
      S_MARK:     state_d = S_OUT;
      S_INIT:     state_d = S_TI_LOAD;
      S_TI_LOAD:  state_d = S_TI;
      S_TI:       if (div_done) state_d = S_FI_LOAD;
      S_FI_LOAD:  state_d = S_FI;
      S_FI:       if (div_done) state_d = S_CHECK;
      S_CHECK:    state_d = S_MUL_A;
      S_MUL_A:    state_d = S_MUL_B;
      S_MUL_B:    state_d = S_OUT;
      S_OUT:      if (out_acc) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d   = phase_q;
    ws_d      = ws_q;
    dc_d      = dc_q;
    tc_d      = tc_q;
    sp_d      = sp_q;
    hs_d      = hs_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    idx_d     = idx_q;
    ti_d      = ti_q;
    fi_d      = fi_q;
    tsl_d     = tsl_q;
    dst_d     = dst_q;
    rsn_d     = rsn_q;
    ev_d      = ev_q;
    slot_d    = slot_q;
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = dst_q;

    unique case (state_q)
      S_DECODE: begin
        dst_d  = DST_TRASH;
        rsn_d  = RSN_NONE;
        ev_d   = EV_NONE;
        slot_d = '0;
        div_rem_d = '0;
        div_cnt_d = '0;
        div_quo_d = {1'b0, cnt_q};
        div_den_d = 32'(HEAP_TABLE_DEPTH);
        if (cmd_q == CMD_STOP) begin
          sp_d = 1'b1;
        end else if (cmd_q == CMD_ALLOC && cnt_q == 48'd1) begin
          // heap counter one is never placed
          rsn_d     = RSN_IGNORED;
          ram_we    = 1'b1;
          ram_addr  = IW'(1);
          ram_wdata = DST_TRASH;
        end
      end
      S_IDX, S_TI, S_FI: begin
        div_rem_d = div_rem_nx;
        div_quo_d = div_quo_nx;
        div_cnt_d = div_cnt_q + 6'd1;
        if (state_q == S_TI && div_done) ti_d = div_quo_nx;
        if (state_q == S_FI && div_done) fi_d = div_quo_nx;
      end
      S_IDX_DONE: begin
        idx_d    = idx_new;
        ram_addr = idx_new;
      end
      S_MARK: begin
        dc_d = dc_dec;
        tc_d = tc_dec;
        case (ram_rdata)
          DST_DATA: dst_d = DST_DATA;
          DST_TEMP: dst_d = DST_TEMP;
          default:  dst_d = DST_TRASH;
        endcase
        if (phase_q == PH_SEQ && tc_dec == '0) begin
          if (bm_q >= 3'd3 && sp_q) begin
            hs_d = 1'b1;
            sp_d = 1'b0;
          end
          ws_d    = ws_q + ds_tk_q;
          dc_d    = 32'(cc_ec_q);
          phase_d = PH_PAR;
          ev_d    = EV_DATA_REL;
        end else if (phase_q == PH_PAR && dc_dec == '0) begin
          tc_d    = 32'd1;
          phase_d = PH_SEQ;
          ev_d    = EV_TEMP_REL;
        end
      end
      S_INIT: begin
        if (phase_q == PH_INIT) begin
          ws_d    = ts_q + {15'd0, tk_q, 1'b0};
          tc_d    = 32'd1;
          phase_d = PH_SEQ;
        end
      end
      S_TI_LOAD: begin
        div_rem_d = '0;
        div_cnt_d = '0;
        div_quo_d = ti_num;
        div_den_d = tk_nz;
      end
      S_FI_LOAD: begin
        div_rem_d = '0;
        div_cnt_d = '0;
        div_quo_d = fi_num;
        div_den_d = cs_nz;
      end
      S_CHECK: begin
        dst_d = DST_TRASH;
        rsn_d = RSN_PLACED;
        tsl_d = ti_q[16:0];
        if (hs_q || ts_q < ws_q) begin
          rsn_d = RSN_SKIPPED;
        end else if (ts_q > ws_q && ti_q >= NUM_W'({ds_q, 2'b00})) begin
          rsn_d = RSN_TIMEERR;
        end else if (eng6 < ef_q || {1'b0, ei} >= ec_q) begin
          rsn_d = RSN_ENGSKIP;
        end else if (fr_q < cf_q || fi_q >= NUM_W'(cc_q)) begin
          rsn_d = RSN_CHANSKIP;
        end else if (phase_q == PH_SEQ) begin
          if (ti_q >= NUM_W'(ds_temp)) begin
            rsn_d = RSN_OVERRUN;
          end else if (ti_q >= NUM_W'(ds_ext)) begin
            dst_d = DST_TEMP;
            tsl_d = ti_q[16:0] - ds_ext;
          end else begin
            dst_d = DST_DATA;
          end
        end else begin
          if (ti_q >= NUM_W'(ds_ext)) begin
            rsn_d = RSN_OVERRUN;
          end else if (ti_q >= NUM_W'(TEMP_SLOTS)) begin
            dst_d = DST_DATA;
          end else begin
            dst_d = DST_TEMP;
          end
        end
        if (bm_q == 3'd0) dst_d = DST_TRASH;
        ram_we    = 1'b1;
        ram_wdata = dst_d;
      end
      S_MUL_A: begin
        slot_d = prod_a[27:0];
      end
      S_MUL_B: begin
        slot_d = (dst_q == DST_TRASH) ? '0 : slot_q + 28'(prod_b) + fi_q[27:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_INIT;
      ws_q    <= '0;
      dc_q    <= '0;
      tc_q    <= '0;
      sp_q    <= 1'b0;
      hs_q    <= 1'b0;
      cf_q    <= '0;
      cs_q    <= 32'd1;
      cc_q    <= 13'd1;
      ef_q    <= '0;
      ec_q    <= 7'd1;
      tk_q    <= 32'd1;
      ds_q    <= 16'd1;
      bm_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ws_q    <= ws_d;
      dc_q    <= dc_d;
      tc_q    <= tc_d;
      sp_q    <= sp_d;
      hs_q    <= hs_d;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_CHANNEL_FIRST: cf_q <= cfg_data_i;
          CFG_CHANNEL_STEP:  cs_q <= cfg_data_i[31:0];
          CFG_CHANNEL_COUNT: cc_q <= cfg_data_i[12:0];
          CFG_ENGINE_FIRST:  ef_q <= cfg_data_i[5:0];
          CFG_ENGINE_COUNT:  ec_q <= cfg_data_i[6:0];
          CFG_TICK_STEP:     tk_q <= cfg_data_i[31:0];
          CFG_DATA_SLOTS:    ds_q <= cfg_data_i[15:0];
          CFG_BUFFER_MODE:   bm_q <= cfg_data_i[2:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_e'(item_i.command);
      cnt_q <= item_i.heap_counter;
      ts_q  <= item_i.timestamp & IMM_MASK;
      eng_q <= item_i.engine_id & IMM_MASK;
      fr_q  <= item_i.frequency & IMM_MASK;
    end
    cc_ec_q   <= 20'(cc_q) * 20'(ec_q);
    ds_tk_q   <= 48'(ds_q) * 48'(tk_q);
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    div_cnt_q <= div_cnt_d;
    idx_q     <= idx_d;
    ti_q      <= ti_d;
    fi_q      <= fi_d;
    tsl_q     <= tsl_d;
    dst_q     <= dst_d;
    rsn_q     <= rsn_d;
    ev_q      <= ev_d;
    slot_q    <= slot_d;
  end

  hsp_ram #(
    .WIDTH (2),
    .DEPTH (HEAP_TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign item_i.ready          = state_q == S_IDLE;
  assign result_o.valid        = state_q == S_OUT;
  assign result_o.destination  = dst_q;
  assign result_o.slot_index   = slot_q;
  assign result_o.reason       = rsn_q;
  assign result_o.switch_event = ev_q;
  assign result_o.stopped      = hs_q;

endmodule

// ----- tb/heap_slot_placement_tb.sv -----
// ----------------------------------------------------------------------------
// heap_slot_placement_tb
// Drives allocate, mark, stop and unused commands into the heap placement
// block over several register settings. Every result is checked field by
// field against a predictor that tracks the phase, window and countdowns, or
// against fixed expected values for the directed items that give them.
module heap_slot_placement_tb;
  import hsp_pkg::*;

  localparam longint unsigned MASK48  = 64'hFFFF_FFFF_FFFF;
  localparam int              TAB_D   = 1024;
  localparam int              N_PHASE = 6;
  localparam int              PER_PH  = 275;
  localparam longint          LIMIT   = 3000000;

  typedef struct packed {
    dst_e        dst;
    logic [27:0] slot;
    rsn_e        rsn;
    ev_e         ev;
    logic        stp;
  } placement_t;

  typedef struct {
    cmd_e            cmd;
    longint unsigned hc, ts, eng, fr;
    bit              known;
    placement_t      res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;

  hsp_in_if  in_if();
  hsp_out_if out_if();

  heap_slot_placement DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_if),
    .result_o   (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // register copies
  longint unsigned r_ch_first, r_ch_step, r_ch_cnt, r_eng_first, r_eng_cnt;
  longint unsigned r_tick, r_slots, r_mode;
  // block state copies
  phase_e          ph;
  longint unsigned win;
  logic [31:0]     data_left, temp_left;
  bit              stop_req, halted;
  dst_e            dest_tab [TAB_D];
  longint unsigned written_q[$];

  placement_t placement_q[$];
  int  fails = 0, n_items = 0, n_results = 0, n_switch = 0, n_placed = 0;
  bit  no_idle = 1'b0;
  bit  allow_stop = 1'b0;
  int  stall_left = 0;
  longint cycles = 0;

  function automatic placement_t place_heap(cmd_e c, longint unsigned hc,
                                            longint unsigned ts, longint unsigned eng,
                                            longint unsigned fr);
    placement_t      r;
    longint unsigned tstep, cstep, ti, ei, fi, e;
    int              idx;
    dst_e            d;
    rsn_e            rs;
    r = '{DST_TRASH, 28'd0, RSN_NONE, EV_NONE, 1'b0};
    hc &= MASK48; ts &= MASK48; eng &= MASK48; fr &= MASK48;
    idx = int'(hc % TAB_D);
    case (c)
      CMD_ALLOC: begin
        written_q.push_back(hc);
        if (hc == 1) begin
          dest_tab[idx] = DST_TRASH;
          r.rsn = RSN_IGNORED;
        end else begin
          e = (eng > 63) ? 0 : eng;
          if (ph == PH_INIT) begin
            win = (ts + 2 * r_tick) & MASK48;
            temp_left = 32'd1;
            ph = PH_SEQ;
          end
          tstep = (r_tick == 0) ? 1 : r_tick;
          cstep = (r_ch_step == 0) ? 1 : r_ch_step;
          ti = (ts >= win) ? (ts - win + tstep / 2) / tstep : 0;
          ei = e - r_eng_first;
          fi = (fr >= r_ch_first) ? (fr - r_ch_first + cstep / 2) / cstep : 0;
          d = DST_TRASH;
          rs = RSN_PLACED;
          if (halted || ts < win) rs = RSN_SKIPPED;
          else if (ts > win && ti >= 4 * r_slots) rs = RSN_TIMEERR;
          else if (e < r_eng_first || ei >= r_eng_cnt) rs = RSN_ENGSKIP;
          else if (fr < r_ch_first || fi >= r_ch_cnt) rs = RSN_CHANSKIP;
          else if (ph == PH_SEQ) begin
            if (ti >= r_slots + 2) rs = RSN_OVERRUN;
            else if (ti >= r_slots) begin
              d = DST_TEMP;
              ti -= r_slots;
            end else d = DST_DATA;
          end else begin
            if (ti >= r_slots) rs = RSN_OVERRUN;
            else if (ti >= 2) d = DST_DATA;
            else d = DST_TEMP;
          end
          if (r_mode == 0) d = DST_TRASH;
          if (d != DST_TRASH)
            r.slot = 28'(ti * r_eng_cnt * r_ch_cnt + ei * r_ch_cnt + fi);
          dest_tab[idx] = d;
          r.dst = d;
          r.rsn = rs;
        end
      end
      CMD_MARK: begin
        r.dst = dest_tab[idx];
        if (r.dst == DST_DATA) data_left--;
        else if (r.dst == DST_TEMP) temp_left--;
        if (ph == PH_SEQ && temp_left == 0) begin
          if (r_mode >= 3 && stop_req) begin
            halted = 1'b1;
            stop_req = 1'b0;
          end
          win = (win + r_slots * r_tick) & MASK48;
          data_left = 32'(r_ch_cnt * r_eng_cnt);
          ph = PH_PAR;
          r.ev = EV_DATA_REL;
        end else if (ph == PH_PAR && data_left == 0) begin
          temp_left = 32'd1;
          ph = PH_SEQ;
          r.ev = EV_TEMP_REL;
        end
      end
      CMD_STOP: stop_req = 1'b1;
      default: ;
    endcase
    r.stp = halted;
    return r;
  endfunction

  function automatic longint unsigned rand48();
    return {$urandom, $urandom} & MASK48;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(cmd_e c, longint unsigned hc, longint unsigned ts,
                           longint unsigned eng, longint unsigned fr, bit known,
                           placement_t res);
    int         gap;
    placement_t p;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.command      = c;
    in_if.heap_counter = hc[47:0];
    in_if.timestamp    = ts[47:0];
    in_if.engine_id    = eng[47:0];
    in_if.frequency    = fr[47:0];
    in_if.valid        = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    p = place_heap(c, hc, ts, eng, fr);
    placement_q.push_back(known ? res : p);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, longint unsigned val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val[47:0];
    @(posedge clk_i);
    case (idx)
      CFG_CHANNEL_FIRST: r_ch_first  = val & MASK48;
      CFG_CHANNEL_STEP:  r_ch_step   = val & 64'hFFFF_FFFF;
      CFG_CHANNEL_COUNT: r_ch_cnt    = val & 64'h1FFF;
      CFG_ENGINE_FIRST:  r_eng_first = val & 64'h3F;
      CFG_ENGINE_COUNT:  r_eng_cnt   = val & 64'h7F;
      CFG_TICK_STEP:     r_tick      = val & 64'hFFFF_FFFF;
      CFG_DATA_SLOTS:    r_slots     = val & 64'hFFFF;
      default:           r_mode      = val & 64'h7;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_phase_regs(int p);
    longint unsigned v[8];
    v[0] = rand48() >> $urandom_range(8, 40);
    v[1] = $urandom_range(1, 1000);
    v[2] = $urandom_range(1, 4);
    v[3] = $urandom_range(0, 63);
    v[4] = $urandom_range(1, 3);
    v[5] = $urandom_range(1, 100000);
    v[6] = $urandom_range(1, 4);
    v[7] = 1;
    case (p)
      1: begin
        // zero steps act as one, smallest counts
        v[0] = 0; v[1] = 0; v[2] = 1; v[3] = 0; v[4] = 1; v[5] = 0; v[6] = 1; v[7] = 2;
      end
      2: v[7] = 0;
      4: v[7] = 3;
      5: begin
        v[0] = MASK48 - 64'hFFFF_FFFF; v[1] = 64'hFFFF_FFFF; v[2] = 4096; v[3] = 63;
        v[4] = 64; v[5] = 64'hFFFF_FFFF; v[6] = 65535; v[7] = 4;
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_e'(i), v[i]);
  endtask

  task automatic random_item();
    int              pick;
    longint unsigned tstep, cstep, hc, ts, eng, fr;
    longint          k;
    pick  = $urandom_range(0, 99);
    tstep = (r_tick == 0) ? 1 : r_tick;
    cstep = (r_ch_step == 0) ? 1 : r_ch_step;
    hc = ($urandom_range(0, 49) == 0) ? 1 : rand48();
    if (pick < 35 && written_q.size() != 0) begin
      hc = written_q[$urandom_range(0, written_q.size() - 1)];
      send_item(CMD_MARK, hc, rand48(), rand48(), rand48(), 1'b0, '0);
    end else if (pick < 38 && allow_stop) begin
      send_item(CMD_STOP, rand48(), rand48(), rand48(), rand48(), 1'b0, '0);
    end else if (pick < 40) begin
      send_item(CMD_UNUSED, rand48(), rand48(), rand48(), rand48(), 1'b0, '0);
    end else if (pick < 48) begin
      // noise allocate
      send_item(CMD_ALLOC, hc, rand48(), rand48(), rand48(), 1'b0, '0);
    end else begin
      k  = longint'($urandom_range(0, 4 * r_slots + 3)) - 1;
      ts = (win + unsigned'(k) * tstep + ($urandom % tstep) - tstep / 2) & MASK48;
      if ($urandom_range(0, 9) == 0) eng = ($urandom_range(0, 1) != 0) ? rand48() : 64;
      else eng = r_eng_first + $urandom_range(0, r_eng_cnt);
      fr = (r_ch_first + cstep * $urandom_range(0, r_ch_cnt) + ($urandom % cstep)
            - cstep / 2) & MASK48;
      send_item(CMD_ALLOC, hc, ts, eng, fr, 1'b0, '0);
    end
  endtask

  // result side
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready = 1'b0;
    else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else out_if.ready = 1'b1;
  end

  always @(posedge clk_i) begin
    placement_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
      if (placement_q.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        want = placement_q.pop_front();
        if (out_if.destination !== want.dst) begin
          $error("destination: expected %0d, got %0d", want.dst, out_if.destination);
          fails++;
        end
        if (out_if.slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_if.slot_index);
          fails++;
        end
        if (out_if.reason !== want.rsn) begin
          $error("reason: expected %0d, got %0d", want.rsn, out_if.reason);
          fails++;
        end
        if (out_if.switch_event !== want.ev) begin
          $error("switch_event: expected %0d, got %0d", want.ev, out_if.switch_event);
          fails++;
        end
        if (out_if.stopped !== want.stp) begin
          $error("stopped: expected %0d, got %0d", want.stp, out_if.stopped);
          fails++;
        end
        if (want.ev != EV_NONE) n_switch++;
        if (want.dst != DST_TRASH) n_placed++;
      end
    end
  end

  row_t rows[$];

  function automatic row_t mk(cmd_e c, longint unsigned hc, longint unsigned ts,
                              longint unsigned eng, longint unsigned fr, bit known,
                              dst_e d, rsn_e rs);
    row_t r;
    r.cmd = c; r.hc = hc; r.ts = ts; r.eng = eng; r.fr = fr; r.known = known;
    r.res = '{d, 28'd0, rs, EV_NONE, 1'b0};
    return r;
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_ALLOC;
    in_if.heap_counter = '0;
    in_if.timestamp = '0;
    in_if.engine_id = '0;
    in_if.frequency = '0;
    out_if.ready = 1'b0;
    r_ch_first = 0; r_ch_step = 1; r_ch_cnt = 1; r_eng_first = 0; r_eng_cnt = 1;
    r_tick = 1; r_slots = 1; r_mode = 0;
    ph = PH_INIT; win = 0; data_left = '0; temp_left = '0;
    stop_req = 1'b0; halted = 1'b0;

    // defaults after reset: everything lands in trash
    rows.push_back(mk(CMD_ALLOC, 1, 7, 3, 9, 1, DST_TRASH, RSN_IGNORED));
    rows.push_back(mk(CMD_MARK, 1, 0, 0, 0, 1, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_STOP, MASK48, MASK48, MASK48, MASK48, 1, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_UNUSED, MASK48, MASK48, MASK48, MASK48, 1, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_ALLOC, 5, 100, 0, 0, 1, DST_TRASH, RSN_SKIPPED));
    rows.push_back(mk(CMD_ALLOC, MASK48, MASK48, MASK48, MASK48, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_ALLOC, 0, 0, 64, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_ALLOC, 6, 102, 0, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_ALLOC, 1025, 103, 63, 1, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_ALLOC, 7, 110, 0, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_MARK, 5, 0, 0, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_MARK, 1025, 0, 0, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_MARK, MASK48, 0, 0, 0, 0, DST_TRASH, RSN_NONE));
    rows.push_back(mk(CMD_MARK, 6, 0, 0, 0, 0, DST_TRASH, RSN_NONE));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].hc, rows[i].ts, rows[i].eng, rows[i].fr,
                rows[i].known, rows[i].res);

    for (int p = 0; p < N_PHASE; p++) begin
      drain();
      set_phase_regs(p);
      no_idle    = (p == 3);
      allow_stop = (p >= 4);
      // random items; marks pick among heaps that were already allocated
      for (int n = 0; n < PER_PH; n++) begin
        random_item();
        if (n == PER_PH / 2 && p == 0) begin
          in_if.valid = 1'b0;
          while (placement_q.size() != 0) @(negedge clk_i);
        end
      end
    end

    in_if.valid = 1'b0;
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("%0d items sent over %0d register settings, %0d results checked",
             n_items, N_PHASE + 1, n_results);
    $display("%0d heaps placed in data or temporary buffers, %0d buffer switches",
             n_placed, n_switch);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
